[hdl/sgr_pkg.sv]
// Shared constants, register codes and control types of the Sobel gradient block.
`timescale 1ns / 1ps
`default_nettype none

package sgr_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  localparam int ROW_W        = 16;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);
  localparam int MIN_DIM = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Per-stage control: a pixel is present, and it completes a 3x3 window.
  typedef struct packed {
    logic valid;
    logic produce;
  } stage_t;

endpackage

`default_nettype wire

[hdl/sgr_line_mem.sv]
// Two-row line store memory: one word holds the pixels of the two rows above.
`timescale 1ns / 1ps
`default_nettype none

module sgr_line_mem #(
  parameter int DEPTH = 1024,
  parameter int DW    = 16
) (
  input  wire                     clk_i,
  input  wire                     rd_en_i,
  input  wire [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DW-1:0]           rd_data_o,
  input  wire                     wr_en_i,
  input  wire [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire [DW-1:0]            wr_data_i
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[hdl/sgr_ctrl.sv]
// Configuration registers and raster position counters of the Sobel gradient block.
`timescale 1ns / 1ps
`default_nettype none

module sgr_ctrl #(
  parameter int MAX_WIDTH = sgr_pkg::MAX_WIDTH_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire [sgr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire [sgr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire                             accept_i,
  output logic [$clog2(MAX_WIDTH)-1:0]    col_o,
  output logic [sgr_pkg::ROW_W-1:0]       row_o,
  output sgr_pkg::stage_t                 s0_o
);

  import sgr_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = $clog2(MAX_WIDTH + 1);

  logic [WIDTH_REG_W-1:0]  width_q, width_d;
  logic [HEIGHT_REG_W-1:0] height_q, height_d;
  logic [CW-1:0]           col_q, col_d;
  logic [ROW_W-1:0]        row_q, row_d;
  logic [EW-1:0]           eff_w;
  logic [HEIGHT_REG_W-1:0] eff_h;
  logic                    col_last, row_last;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:  width_d  = cfg_data_i[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_d = cfg_data_i[HEIGHT_REG_W-1:0];
        default:          width_d  = width_q;
      endcase
    end
  end

  // Clamp the programmed frame size.
  always_comb begin
    if (32'(width_q) < 32'(MIN_DIM)) begin
      eff_w = EW'(MIN_DIM);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_q);
    end
    if (32'(height_q) < 32'(MIN_DIM)) begin
      eff_h = HEIGHT_REG_W'(MIN_DIM);
    end else begin
      eff_h = height_q;
    end
  end

  assign col_last = (32'(col_q) + 32'd1) >= 32'(eff_w);
  assign row_last = (32'(row_q) + 32'd1) >= 32'(eff_h);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  assign col_o        = col_q;
  assign row_o        = row_q;
  assign s0_o.valid   = accept_i;
  assign s0_o.produce = (col_q >= CW'(2)) && (row_q >= ROW_W'(2));

endmodule

`default_nettype wire

[hdl/sgr_window.sv]
// Line store write-back, 3x3 window columns and Sobel gradient arithmetic.
`timescale 1ns / 1ps
`default_nettype none

module sgr_window #(
  parameter int MAX_WIDTH  = sgr_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = sgr_pkg::PIXEL_BITS_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  sgr_pkg::stage_t                 s0_i,
  input  wire [PIXEL_BITS-1:0]            pixel_i,
  input  wire [$clog2(MAX_WIDTH)-1:0]     col_i,
  input  wire [sgr_pkg::ROW_W-1:0]        row_i,
  input  wire [2*PIXEL_BITS-1:0]          rd_data_i,
  output logic                            wr_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0]    wr_addr_o,
  output logic [2*PIXEL_BITS-1:0]         wr_data_o,
  output logic                            push_o,
  output logic signed [PIXEL_BITS+2:0]    gx_o,
  output logic signed [PIXEL_BITS+2:0]    gy_o,
  output logic [$clog2(MAX_WIDTH)-1:0]    ccol_o,
  output logic [sgr_pkg::ROW_W-1:0]       crow_o
);

  import sgr_pkg::*;

  localparam int PB = PIXEL_BITS;
  localparam int CW = $clog2(MAX_WIDTH);

  stage_t        s1_q;
  logic [PB-1:0] pix_q;
  logic [CW-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [PB-1:0] win_q [6];
  logic [PB-1:0] top, mid;
  logic [PB+1:0] sx_r, sx_l, sy_b, sy_t;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= s0_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_i.valid) begin
      pix_q <= pixel_i;
      col_q <= col_i;
      row_q <= row_i;
    end
  end

  assign top = rd_data_i[2*PB-1:PB];
  assign mid = rd_data_i[PB-1:0];

  // Shift the window left by one column.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_q.valid) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top;
      win_q[4] <= mid;
      win_q[5] <= pix_q;
    end
  end

  // Rotate the column: the middle row moves up, the new pixel becomes the middle row.
  assign wr_en_o   = s1_q.valid;
  assign wr_addr_o = col_q;
  assign wr_data_o = {mid, pix_q};

  assign sx_r = {2'b00, top} + {1'b0, mid, 1'b0} + {2'b00, pix_q};
  assign sx_l = {2'b00, win_q[0]} + {1'b0, win_q[1], 1'b0} + {2'b00, win_q[2]};
  assign sy_b = {2'b00, win_q[2]} + {1'b0, win_q[5], 1'b0} + {2'b00, pix_q};
  assign sy_t = {2'b00, win_q[0]} + {1'b0, win_q[3], 1'b0} + {2'b00, top};

  assign gx_o   = $signed({1'b0, sx_r}) - $signed({1'b0, sx_l});
  assign gy_o   = $signed({1'b0, sy_b}) - $signed({1'b0, sy_t});
  assign ccol_o = col_q - CW'(1);
  assign crow_o = row_q - ROW_W'(1);
  assign push_o = s1_q.valid && s1_q.produce;

endmodule

`default_nettype wire

[hdl/sgr_out_buf.sv]
// Two-entry result buffer that decouples the gradient stage from output stall.
`timescale 1ns / 1ps
`default_nettype none

module sgr_out_buf #(
  parameter int GW = 11,
  parameter int CW = 10,
  parameter int RW = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  wire signed [GW-1:0]  gx_i,
  input  wire signed [GW-1:0]  gy_i,
  input  wire [CW-1:0]         ccol_i,
  input  wire [RW-1:0]         crow_i,
  output logic                 pop_o,
  output logic [1:0]           count_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic signed [GW-1:0] grad_x_o,
  output logic signed [GW-1:0] grad_y_o,
  output logic [CW-1:0]        center_col_o,
  output logic [RW-1:0]        center_row_o
);

  localparam int EW = 2 * GW + CW + RW;

  logic [EW-1:0] ent_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          pop;

  assign pop = (count_q != 2'd0) && !out_stall_i;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= {gx_i, gy_i, ccol_i, crow_i};
    end
  end

  assign {grad_x_o, grad_y_o, center_col_o, center_row_o} = ent_q[rd_ptr_q];
  assign out_valid_o = (count_q != 2'd0);
  assign pop_o       = pop;
  assign count_o     = count_q;

endmodule

`default_nettype wire

[hdl/sobel_gradient_3x3.sv]
// Top level of the 3x3 Sobel gradient filter for a raster-order pixel stream.
`timescale 1ns / 1ps
`default_nettype none

// Sobel 3x3 gradient filter. Pixels of one image plane enter in raster order, one
// transaction per pixel, and the block takes one pixel every clock cycle when the
// output side keeps up. For each pixel at row >= 2 and column >= 2 it delivers one
// result: the signed horizontal and vertical gradients of the window centered one
// row up and one column left, with that center's column and row. Border pixels
// give no result. The accepted pixel and its line store word are registered, the
// gradients come from them and the result goes into the buffer. The rate
// is set by the line store: a single memory, as deep as the
// widest row, holding the two previous rows side by side in each word; every
// pixel reads its column once and writes the rotated column back on the next
// cycle. Results go through a two-entry buffer, so the input keeps flowing while
// the output side takes results; the input stalls whenever the buffer will hold
// two results after the current edge, whether or not the next pixel makes one.
// Write image_width and image_height only while the block is idle; width is
// clamped to 3..MAX_WIDTH and height to at least 3. After the last pixel of the
// last row, the counters return to the first pixel of a new frame. The line
// store is not cleared at reset; the first two rows of each frame fill it
// before any of its contents is used.

module sobel_gradient_3x3 #(
  parameter int MAX_WIDTH  = sgr_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = sgr_pkg::PIXEL_BITS_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // configuration write channel
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire [sgr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire [sgr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // pixel input channel
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire [PIXEL_BITS-1:0]            pixel_i,
  // result output channel
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic signed [PIXEL_BITS+2:0]    grad_x_o,
  output logic signed [PIXEL_BITS+2:0]    grad_y_o,
  output logic [$clog2(MAX_WIDTH)-1:0]    center_col_o,
  output logic [sgr_pkg::ROW_W-1:0]       center_row_o
);

  import sgr_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int GW = PIXEL_BITS + 3;
  localparam int MW = 2 * PIXEL_BITS;

  logic                 accept;
  stage_t               s0;
  logic [CW-1:0]        col;
  logic [ROW_W-1:0]     row;
  logic [MW-1:0]        mem_rd_data;
  logic                 mem_wr_en;
  logic [CW-1:0]        mem_wr_addr;
  logic [MW-1:0]        mem_wr_data;
  logic                 push;
  logic signed [GW-1:0] gx, gy;
  logic [CW-1:0]        ccol;
  logic [ROW_W-1:0]     crow;
  logic                 pop;
  logic [1:0]           count;
  logic [1:0]           fill_next;

  // Hold the input when the pixel now in the gradient stage, together with what
  // the buffer keeps after this cycle, would leave no room for this pixel's result.
  assign fill_next  = count + 2'(push) - 2'(pop);
  assign in_stall_o = fill_next[1];
  assign accept     = in_valid_i && !in_stall_o;

  sgr_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .col_o       (col),
    .row_o       (row),
    .s0_o        (s0)
  );

  // Read the column of the accepted pixel; the word comes back next cycle.
  // Consecutive pixels never share a column, so the write-back of one pixel and
  // the read of the next always hit different entries.
  sgr_line_mem #(
    .DEPTH (MAX_WIDTH),
    .DW    (MW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (s0.valid),
    .rd_addr_i (col),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  sgr_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s0_i      (s0),
    .pixel_i   (pixel_i),
    .col_i     (col),
    .row_i     (row),
    .rd_data_i (mem_rd_data),
    .wr_en_o   (mem_wr_en),
    .wr_addr_o (mem_wr_addr),
    .wr_data_o (mem_wr_data),
    .push_o    (push),
    .gx_o      (gx),
    .gy_o      (gy),
    .ccol_o    (ccol),
    .crow_o    (crow)
  );

  sgr_out_buf #(
    .GW (GW),
    .CW (CW),
    .RW (ROW_W)
  ) u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .gx_i         (gx),
    .gy_i         (gy),
    .ccol_i       (ccol),
    .crow_i       (crow),
    .pop_o        (pop),
    .count_o      (count),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .grad_x_o     (grad_x_o),
    .grad_y_o     (grad_y_o),
    .center_col_o (center_col_o),
    .center_row_o (center_row_o)
  );

  // Write-back of one pixel never collides with the read of the next one.
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0.valid && mem_wr_en) |-> (col != mem_wr_addr))
    else $error("line store read and write-back hit the same column");

  // A result never lands in a full buffer.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (count != 2'd2 || pop))
    else $error("result buffer overflow");

  // A pixel that completes a window yields a result on the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s0.produce) |=> push)
    else $error("completed window produced no result");

endmodule

`default_nettype wire

[sim/sobel_gradient_3x3_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the Sobel gradient filter: watches all channels, predicts and compares results.

module sobel_gradient_3x3_checker #(
  parameter int MAX_WIDTH  = sgr_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = sgr_pkg::PIXEL_BITS_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_valid_i,
  input  wire                                cfg_ready_i,
  input  wire [sgr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire [sgr_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire                                in_valid_i,
  input  wire                                in_stall_i,
  input  wire [PIXEL_BITS-1:0]               pixel_i,
  input  wire                                out_valid_i,
  input  wire                                out_stall_i,
  input  wire signed [PIXEL_BITS+2:0]        grad_x_i,
  input  wire signed [PIXEL_BITS+2:0]        grad_y_i,
  input  wire [$clog2(MAX_WIDTH)-1:0]        center_col_i,
  input  wire [sgr_pkg::ROW_W-1:0]           center_row_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);

  localparam int GRAD_W       = PIXEL_BITS + 3;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [GRAD_W-1:0]   grad_x;
    logic signed [GRAD_W-1:0]   grad_y;
    logic [COL_W-1:0]           center_col;
    logic [sgr_pkg::ROW_W-1:0]  center_row;
  } gradient_t;

  logic [PIXEL_BITS-1:0]             line_two_up [MAX_WIDTH];
  logic [PIXEL_BITS-1:0]             line_one_up [MAX_WIDTH];
  // older two window columns: top, middle, bottom of each
  logic [PIXEL_BITS-1:0]             win [6];
  logic [COL_W-1:0]                  col_pos;
  logic [sgr_pkg::ROW_W-1:0]         row_pos;
  logic [sgr_pkg::WIDTH_REG_W-1:0]   width_reg;
  logic [sgr_pkg::HEIGHT_REG_W-1:0]  height_reg;
  gradient_t                         gradient_queue [$];
  int                                fails;

  // Shift one pixel into the window; return 1 when it completes an interior window.
  function automatic bit slide_window(input logic [PIXEL_BITS-1:0] pix, output gradient_t res);
    int slot, eff_w, eff_h;
    int tl, ml, bl, tc, bc, tr, mr, br;
    bit hit;
    slot = int'(col_pos) % MAX_WIDTH;
    tr = int'(line_two_up[slot]);
    mr = int'(line_one_up[slot]);
    br = int'(pix);
    line_two_up[slot] = line_one_up[slot];
    line_one_up[slot] = pix;
    tl = int'(win[0]);
    ml = int'(win[1]);
    bl = int'(win[2]);
    tc = int'(win[3]);
    bc = int'(win[5]);
    hit = (col_pos >= 2) && (row_pos >= 2);
    res.grad_x     = GRAD_W'((tr + 2 * mr + br) - (tl + 2 * ml + bl));
    res.grad_y     = GRAD_W'((bl + 2 * bc + br) - (tl + 2 * tc + tr));
    res.center_col = col_pos - 1'b1;
    res.center_row = row_pos - 1'b1;
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = PIXEL_BITS'(tr);
    win[4] = PIXEL_BITS'(mr);
    win[5] = pix;
    eff_w = int'(width_reg);
    if (eff_w < sgr_pkg::MIN_DIM) eff_w = sgr_pkg::MIN_DIM;
    if (eff_w > MAX_WIDTH) eff_w = MAX_WIDTH;
    eff_h = int'(height_reg);
    if (eff_h < sgr_pkg::MIN_DIM) eff_h = sgr_pkg::MIN_DIM;
    if (int'(col_pos) + 1 >= eff_w) begin
      col_pos = '0;
      if (int'(row_pos) + 1 >= eff_h) row_pos = '0;
      else row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return hit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    gradient_t fresh, want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
        line_two_up[i] = '0;
        line_one_up[i] = '0;
      end
      for (int i = 0; i < 6; i++) win[i] = '0;
      col_pos    = '0;
      row_pos    = '0;
      width_reg  = sgr_pkg::WIDTH_RESET;
      height_reg = sgr_pkg::HEIGHT_RESET;
      gradient_queue.delete();
      fails = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == sgr_pkg::REG_IMAGE_WIDTH)
          width_reg = cfg_data_i[sgr_pkg::WIDTH_REG_W-1:0];
        else if (cfg_index_i == sgr_pkg::REG_IMAGE_HEIGHT)
          height_reg = cfg_data_i[sgr_pkg::HEIGHT_REG_W-1:0];
      end
      if (in_valid_i && !in_stall_i) begin
        if (slide_window(pixel_i, fresh)) gradient_queue.push_back(fresh);
      end
      if (out_valid_i && !out_stall_i) begin
        if (gradient_queue.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("%0t: unexpected result gx %0d gy %0d col %0d row %0d", $realtime,
                     grad_x_i, grad_y_i, center_col_i, center_row_i);
        end else begin
          want = gradient_queue.pop_front();
          if (grad_x_i !== want.grad_x || grad_y_i !== want.grad_y ||
              center_col_i !== want.center_col || center_row_i !== want.center_row) begin
            fails++;
            if (fails <= REPORT_LIMIT)
              $display({"%0t: result mismatch: expected gx %0d gy %0d col %0d row %0d,",
                        " got gx %0d gy %0d col %0d row %0d"},
                       $realtime, want.grad_x, want.grad_y, want.center_col, want.center_row,
                       grad_x_i, grad_y_i, center_col_i, center_row_i);
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= gradient_queue.size();
  end

endmodule

[sim/sobel_gradient_3x3_test.sv]
`timescale 1ns / 1ps
// Testbench top: drives pixel frames and geometry writes into the Sobel filter, gives the verdict.

module sobel_gradient_3x3_test;
  import sgr_pkg::*;

  localparam int PIX_W        = PIXEL_BITS_DEF;
  localparam int GRAD_W       = PIXEL_BITS_DEF + 3;
  localparam int COL_W        = $clog2(MAX_WIDTH_DEF);
  // pixels of small random frames before the stimulus stops
  localparam int SMALL_PIXELS = 820;
  // long receiver hold-off that backs the block up into its input
  localparam int LONG_HOLD    = 400;
  // cycles let pass after the last result, so border pixels leave the pipe
  localparam int SETTLE       = 8;
  localparam int CYCLE_LIMIT  = 1000000;

  logic                    clk;
  logic                    rst_n     = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data  = '0;
  logic                    in_valid  = 1'b0;
  logic [PIX_W-1:0]        pixel     = '0;
  logic                    out_stall = 1'b0;
  logic                    cfg_ready;
  logic                    in_stall;
  logic                    out_valid;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic [COL_W-1:0]        center_col;
  logic [ROW_W-1:0]        center_row;
  int                      fail_count;
  int                      pending;

  // Stimulus bookkeeping: effective geometry and where the next pixel lands.
  int eff_w         = WIDTH_RESET;
  int eff_h         = HEIGHT_RESET;
  int raster_col    = 0;
  int raster_row    = 0;
  int frames_done   = 0;
  int pixels_sent   = 0;
  int hold_requests = 0;
  bit sender_idling = 1'b1;
  bit stall_idling  = 1'b1;

  sobel_gradient_3x3 i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .pixel_i      (pixel),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .grad_x_o     (grad_x),
    .grad_y_o     (grad_y),
    .center_col_o (center_col),
    .center_row_o (center_row)
  );

  sobel_gradient_3x3_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .pixel_i      (pixel),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .grad_x_i     (grad_x),
    .grad_y_i     (grad_y),
    .center_col_i (center_col),
    .center_row_i (center_row),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off when the stimulus asks.
  initial begin : result_sink
    int holds_served;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (stall_idling && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Mostly uniform samples, with a good share of full-scale black and white.
  function automatic logic [PIX_W-1:0] any_pixel();
    case ($urandom_range(0, 3))
      0:       return ($urandom_range(0, 1) != 0) ? {PIX_W{1'b1}} : {PIX_W{1'b0}};
      default: return PIX_W'($urandom());
    endcase
  endfunction

  // Offer one pixel and hold it until the block takes the transaction, then advance
  // our own raster position the way the block's counters move.
  task automatic push_pixel(input logic [PIX_W-1:0] value);
    if (sender_idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
    raster_col++;
    if (raster_col >= eff_w) begin
      raster_col = 0;
      raster_row++;
      if (raster_row >= eff_h) begin
        raster_row = 0;
        frames_done++;
      end
    end
  endtask

  // Finish the frame in progress, then n - 1 more whole frames.
  task automatic send_frames(input int n);
    int target;
    target = frames_done + n;
    while (frames_done < target) push_pixel(any_pixel());
  endtask

  task automatic send_pixels(input int n);
    repeat (n) push_pixel(any_pixel());
  endtask

  // Drop valid and wait until every predicted result has been delivered. Pending is
  // registered in the checker, so let it update before trusting it.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write both geometry registers back to back on an idle block; valid stays high
  // across the two transactions.
  task automatic write_geometry(input logic [CFG_DATA_W-1:0] width_val,
                                input logic [CFG_DATA_W-1:0] height_val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= width_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= height_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    // the block clamps out-of-range geometry when it uses it
    eff_w = int'(width_val[WIDTH_REG_W-1:0]);
    if (eff_w < MIN_DIM) eff_w = MIN_DIM;
    if (eff_w > MAX_WIDTH_DEF) eff_w = MAX_WIDTH_DEF;
    eff_h = int'(height_val[HEIGHT_REG_W-1:0]);
    if (eff_h < MIN_DIM) eff_h = MIN_DIM;
  endtask

  initial begin : stimulus
    int w, h, n, phase, small_start;
    bit at_start, tail;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: two 3x3 frames that hit the gradient extremes. A vertical ramp
    // gives the largest positive horizontal gradient, a top-bright frame the most
    // negative vertical one. Back to back frames also cover the frame wrap.
    write_geometry(CFG_DATA_W'(3), CFG_DATA_W'(3));
    for (int k = 0; k < 9; k++)
      push_pixel(k % 3 == 0 ? 8'h00 : (k % 3 == 1 ? 8'h80 : 8'hFF));
    for (int k = 0; k < 9; k++)
      push_pixel(k / 3 == 0 ? 8'hFF : (k / 3 == 1 ? 8'h80 : 8'h00));

    // A width beyond the limit (clamped to the full line store), with junk in the
    // unused upper data bits; stay in the first row.
    write_geometry({5'($urandom()), 11'($urandom_range(MAX_WIDTH_DEF + 1, 2047))},
                   CFG_DATA_W'(3));
    send_pixels($urandom_range(1, 60));

    // Exact maximum width, still in the first row, so the next write has to shrink
    // inside a frame.
    write_geometry(CFG_DATA_W'(MAX_WIDTH_DEF), CFG_DATA_W'($urandom_range(3, 480)));
    send_pixels($urandom_range(1, 60));

    // Random phases of small frames. Inside a frame the width may only shrink, so
    // the line store is never read where no row has written it. Each geometry write
    // first drains, which also makes the sender pause until every result is back.
    small_start = pixels_sent;
    phase = 0;
    while (pixels_sent - small_start < SMALL_PIXELS) begin
      at_start = (raster_col == 0) && (raster_row == 0);
      tail     = (pixels_sent - small_start) >= SMALL_PIXELS * 4 / 5;
      if (at_start) begin
        case ($urandom_range(0, 9))
          0:       w = $urandom_range(0, MIN_DIM - 1);
          1:       w = $urandom_range(17, 48);
          default: w = $urandom_range(3, 16);
        endcase
      end else begin
        w = $urandom_range(0, eff_w < 16 ? eff_w : 16);
      end
      case ($urandom_range(0, 9))
        0:       h = $urandom_range(0, MIN_DIM - 1);
        1:       h = $urandom_range(40, 65535);
        default: h = $urandom_range(3, 8);
      endcase
      // tallest frame early on, and a small one for the hold-off phase
      if (phase == 0) h = 65535;
      if (phase == 1) begin
        h = 8;
        if (w > 8) w = 8;
      end
      write_geometry({5'($urandom()), 11'(w)}, CFG_DATA_W'(h));

      // Quiet stretches here and there; no idling at all near the end.
      sender_idling = !tail && ($urandom_range(0, 3) != 0);
      stall_idling  = !tail && ($urandom_range(0, 3) != 0);

      if (phase == 1) begin
        // hold results off for a long time while pixels keep coming
        sender_idling = 1'b0;
        hold_requests++;
        send_frames(4);
      end else if (eff_w * eff_h <= 96 && $urandom_range(0, 3) != 0) begin
        send_frames($urandom_range(1, 2));
      end else begin
        n = SMALL_PIXELS - (pixels_sent - small_start);
        if (n > 6 * eff_w) n = 6 * eff_w;
        send_pixels($urandom_range(1, n));
      end
      phase++;
    end

    drain();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
